>>> src/salc_pkg.sv
// Shared types, sizes and helpers of the set-associative LRU cache directory.
`timescale 1ns / 1ps

package salc_pkg;

  localparam int MAX_SETS   = 256;
  localparam int WAYS       = 8;
  localparam int ADDR_WIDTH = 32;

  localparam int SET_AW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_IW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CW   = $clog2(WAYS + 1);
  localparam int LIMIT_W  = RANK_W + 1;
  localparam int CNT_W    = 32;

  // Configuration register fields, fixed by the register map.
  localparam int OFFSET_W = 5;
  localparam int SETB_W   = 4;
  localparam int WAYSU_W  = 4;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 5;

  typedef enum logic [CFG_IW-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_SET_BITS    = 2'd1,
    REG_WAYS_USED   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SECOND
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [RANK_W-1:0]     rank;
    logic [ADDR_WIDTH-1:0] tag;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  typedef struct packed {
    row_t     row;
    outcome_t outcome;
  } upd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == {CNT_W{1'b1}}) ? x : x + 1'b1;
  endfunction

endpackage

>>> src/salc_row_ram.sv
// Set row memory: one row holds valid, rank and tag of every way in a set.
`timescale 1ns / 1ps

module salc_row_ram
  import salc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SET_AW-1:0] waddr,
  input  row_t              wdata,
  input  logic              re,
  input  logic [SET_AW-1:0] raddr,
  output row_t              rdata
);

  row_t mem [MAX_SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/salc_update.sv
// Lookup and LRU update of one set row for one access.
`timescale 1ns / 1ps

module salc_update
  import salc_pkg::*;
(
  input  row_t                  row,
  input  logic [ADDR_WIDTH-1:0] blk,
  input  logic [WAY_CW-1:0]     nways,
  output upd_t                  upd
);

  logic [WAYS-1:0]    in_use;
  logic [WAYS-1:0]    hit_vec;
  logic [WAYS-1:0]    free_vec;
  logic [WAY_IW-1:0]  hit_way;
  logic [WAY_IW-1:0]  free_way;
  logic [WAY_IW-1:0]  victim;
  logic [RANK_W-1:0]  worst;
  logic [WAY_IW-1:0]  target;
  logic [LIMIT_W-1:0] limit;
  row_t               new_row;
  outcome_t           outcome;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      in_use[w]   = WAY_CW'(w) < nways;
      hit_vec[w]  = in_use[w] && row[w].valid && (row[w].tag == blk);
      free_vec[w] = in_use[w] && !row[w].valid;
    end

    // Lowest index wins for both searches.
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_IW'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_IW'(w);
      end
    end

    // Victim is the largest rank in use; a tie keeps the lower way.
    victim = '0;
    worst  = row[0].rank;
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (row[w].rank > worst)) begin
        worst  = row[w].rank;
        victim = WAY_IW'(w);
      end
    end

    if (|hit_vec) begin
      outcome = OUT_HIT;
      target  = hit_way;
      limit   = {1'b0, row[hit_way].rank};
    end else if (|free_vec) begin
      outcome = OUT_FILL;
      target  = free_way;
      limit   = LIMIT_W'(WAYS);
    end else begin
      outcome = OUT_EVICT;
      target  = victim;
      limit   = {1'b0, worst};
    end

    // The target itself is never aged: it is invalid or sits at the limit.
    new_row = row;
    for (int w = 0; w < WAYS; w++) begin
      if (in_use[w] && row[w].valid && ({1'b0, row[w].rank} < limit)
          && (row[w].rank < RANK_W'(WAYS - 1))) begin
        new_row[w].rank = row[w].rank + 1'b1;
      end
    end
    new_row[target].valid = 1'b1;
    new_row[target].tag   = blk;
    new_row[target].rank  = '0;

    upd.row     = new_row;
    upd.outcome = outcome;
  end

endmodule

>>> src/set_associative_lru_cache.sv
// Top level of the set-associative LRU cache directory.
//
// Usage: an access is transferred at a rising edge with start high and busy
// low; access_address is the byte address and mode 1 (modify) makes two
// accesses to the same address. Each access gives one result, shown for
// exactly one cycle with done high: outcome (hit, fill of an empty line,
// eviction), the saturating hit, miss and eviction totals after it, and
// last on the final result of the item. The receiver cannot stall.
// Timing: the set row is read from a registered synchronous memory in the
// transfer cycle, updated and written back in the next, and done follows
// in the cycle after that, registered from the update. In a modify the
// second access works on the forwarded row. A new access is taken only
// back in the idle state, after the last update of the item.
// Configuration: cfg_index selects offset_bits (0), set_bits (1) or
// ways_used (2); a transfer happens when cfg_valid and cfg_ready are high,
// and cfg_ready is always high. Write it only while the block is idle.
// Reset: rst clears the totals and done and resets the configuration; a
// clearing pass then zeroes all MAX_SETS (256) set rows, busy high throughout.
`timescale 1ns / 1ps

module set_associative_lru_cache
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_WIDTH-1:0] access_address,
  input  logic                  mode,
  output logic                  done,
  output logic [1:0]            outcome,
  output logic [CNT_W-1:0]      hit_count,
  output logic [CNT_W-1:0]      miss_count,
  output logic [CNT_W-1:0]      eviction_count,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_data
);

  state_t                state, state_next;
  logic [OFFSET_W-1:0]   offset_bits;
  logic [SETB_W-1:0]     set_bits;
  logic [WAYSU_W-1:0]    ways_used;
  logic [SET_AW-1:0]     clr_idx;
  logic [ADDR_WIDTH-1:0] blk;
  logic [SET_AW-1:0]     set_idx;
  logic                  twice;
  row_t                  fwd_row;

  logic                  accept;
  logic [ADDR_WIDTH-1:0] in_blk;
  logic [SET_AW-1:0]     in_set;
  logic [SETB_W-1:0]     sb;
  logic [WAY_CW-1:0]     nways;
  row_t                  rd_row;
  row_t                  cur_row;
  upd_t                  upd;
  logic                  mem_we;
  logic [SET_AW-1:0]     mem_waddr;
  row_t                  mem_wdata;
  logic                  working;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Block number and set index of the incoming address.
  always_comb begin
    in_blk = access_address >> offset_bits;
    sb     = (set_bits > SETB_W'(SET_AW)) ? SETB_W'(SET_AW) : set_bits;
    for (int i = 0; i < SET_AW; i++) begin
      in_set[i] = in_blk[i] && (SETB_W'(i) < sb);
    end
  end

  always_comb begin
    if (ways_used == '0) begin
      nways = WAY_CW'(1);
    end else if (WAY_CW'(ways_used) > WAY_CW'(WAYS)) begin
      nways = WAY_CW'(WAYS);
    end else begin
      nways = WAY_CW'(ways_used);
    end
  end

  salc_row_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (rd_row)
  );

  assign cur_row = (state == ST_SECOND) ? fwd_row : rd_row;

  salc_update u_update (
    .row   (cur_row),
    .blk   (blk),
    .nways (nways),
    .upd   (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    working    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = set_idx;
    mem_wdata  = upd.row;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
        if (clr_idx == SET_AW'(MAX_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        working    = 1'b1;
        mem_we     = 1'b1;
        state_next = twice ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        working    = 1'b1;
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_W'(4);
      set_bits    <= SETB_W'(4);
      ways_used   <= WAYSU_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data[OFFSET_W-1:0];
        REG_SET_BITS:    set_bits    <= cfg_data[SETB_W-1:0];
        REG_WAYS_USED:   ways_used   <= cfg_data[WAYSU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Access context and forwarded row for the second access of a modify.
  always_ff @(posedge clk) begin
    if (accept) begin
      blk     <= in_blk;
      set_idx <= in_set;
      twice   <= mode;
    end
    if (working) begin
      fwd_row <= upd.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else begin
      done <= working;
      if (working) begin
        unique case (upd.outcome)
          OUT_HIT: begin
            hit_count <= sat_inc(hit_count);
          end
          OUT_FILL: begin
            miss_count <= sat_inc(miss_count);
          end
          OUT_EVICT: begin
            miss_count     <= sat_inc(miss_count);
            eviction_count <= sat_inc(eviction_count);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (working) begin
      outcome <= upd.outcome;
      last    <= (state == ST_SECOND) || !twice;
    end
  end

endmodule
